@@ rtl/sgwl_pkg.sv @@
package sgwl_pkg;

  // Geometry of the managed space (powers of two, so field splits are bit slices)
  localparam int PAGES_PER_BLK    = 64;
  localparam int BLKS_PER_PLANE   = 256;
  localparam int PLANES_PER_DIE_N = 2;
  localparam int DIES_PER_PKG     = 2;
  localparam int PACKAGES         = 2;

  localparam int TOTAL_PAGES = PAGES_PER_BLK * BLKS_PER_PLANE * PLANES_PER_DIE_N
                               * DIES_PER_PKG * PACKAGES;

  localparam int PG_BITS  = $clog2(PAGES_PER_BLK);
  localparam int BLK_BITS = $clog2(BLKS_PER_PLANE);
  localparam int PLN_BITS = $clog2(PLANES_PER_DIE_N);
  localparam int DIE_BITS = $clog2(DIES_PER_PKG);
  localparam int PKG_BITS = $clog2(PACKAGES);

  localparam int BLK_LSB = PG_BITS;
  localparam int PLN_LSB = BLK_LSB + BLK_BITS;
  localparam int DIE_LSB = PLN_LSB + PLN_BITS;
  localparam int PKG_LSB = DIE_LSB + DIE_BITS;

  localparam int PAGE_W = 17;
  localparam int CNT_W  = 16;

  // Number of logical pages; also the reset position of the gap
  localparam logic [PAGE_W-1:0] SPAN = PAGE_W'(TOTAL_PAGES - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0]  INTERVAL_RST = CNT_W'(100);

  typedef enum logic [1:0] {
    ACT_READ      = 2'd0,
    ACT_WRITE     = 2'd1,
    ACT_MOVE_DONE = 2'd2
  } action_t;

  // Mapping state shared from the controller to the translator
  typedef struct packed {
    logic [PAGE_W-1:0] start_offset;
    logic [PAGE_W-1:0] gap_position;
  } map_state_t;

  typedef struct packed {
    logic [PAGE_W-1:0] move_to;
    logic [PAGE_W-1:0] move_from;
    logic              move_request;
  } move_t;

  typedef struct packed {
    logic              range_error;
    move_t             mv;
    logic              package_index;
    logic              die_index;
    logic              plane_index;
    logic [7:0]        block_index;
    logic [5:0]        page_in_block;
    logic [PAGE_W-1:0] physical_page;
  } result_t;

endpackage

@@ rtl/start_gap_wear_leveler_top.sv @@
// Start-Gap wear leveler: translates logical page beats to physical pages
// over TOTAL_PAGES physical pages holding one page fewer of logical data.
// Input channel (in_*): tuser carries the action (read map, write map, gap
// move done), tdata the logical page. Output channel (out_*): one result beat
// per input beat, with the physical page, its page/block/plane/die/package
// split and, on a write that hits the interval, a move request naming the
// source page and the gap page. tuser flags move request and range error.
// Configuration: cfg_we/cfg_wdata write the move interval (reset 100); write
// only while no beat is in flight.
// Pipeline: an input beat goes into the input register, then through translation
// and state update into the result register, which holds the result beat.
// Throughput: one beat per cycle while out_tready stays high; the limit is the
// combinational add/compare of the translation and the in-order update of the start/gap state.
// Stall: when out_tready is low the result holds; the input register still
// takes one more beat if it is empty, then in_tready falls until the result drains.
// Reset (rst_n low, synchronous): start 0, gap at the last page, write count
// 0, no move pending, both pipeline registers empty.
module start_gap_wear_leveler_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [16:0] logical_page, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [16:0] physical_page, [22:17] page_in_block,
                                  // [30:23] block_index, [31] plane_index,
                                  // [32] die_index, [33] package_index,
                                  // [50:34] move_from, [67:51] move_to, rest zero
  output logic [1:0]  out_tuser   // [0] move_request, [1] range_error
);

  // input register
  logic                          in_valid_r;
  sgwl_pkg::action_t             act_r;
  logic [sgwl_pkg::PAGE_W-1:0]   la_r;
  // result register
  logic                          out_valid_r;
  sgwl_pkg::result_t             res_r, res_nxt;

  logic                          advance;
  logic                          fire;
  logic                          is_map;
  sgwl_pkg::map_state_t          st;
  sgwl_pkg::move_t               mv;
  logic                          map_err;
  logic [sgwl_pkg::PAGE_W-1:0]   map_pa;
  logic [5:0]                    map_pg;
  logic [7:0]                    map_blk;
  logic                          map_pln;
  logic                          map_die;
  logic                          map_pkg;

  // result slot frees when empty or being taken this cycle
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      act_r <= sgwl_pkg::action_t'(in_tuser);
      la_r  <= in_tdata[sgwl_pkg::PAGE_W-1:0];
    end
  end

  sgwl_map u_map (
    .logical_page  (la_r),
    .st            (st),
    .range_error   (map_err),
    .physical_page (map_pa),
    .page_in_block (map_pg),
    .block_index   (map_blk),
    .plane_index   (map_pln),
    .die_index     (map_die),
    .package_index (map_pkg)
  );

  sgwl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fire        (fire),
    .action      (act_r),
    .range_error (map_err),
    .st          (st),
    .mv          (mv)
  );

  // only read and write beats carry a mapping; others give an all-zero result
  assign is_map = (act_r == sgwl_pkg::ACT_READ) || (act_r == sgwl_pkg::ACT_WRITE);

  always_comb begin
    res_nxt = '0;
    if (is_map) begin
      res_nxt.range_error   = map_err;
      res_nxt.physical_page = map_pa;
      res_nxt.page_in_block = map_pg;
      res_nxt.block_index   = map_blk;
      res_nxt.plane_index   = map_pln;
      res_nxt.die_index     = map_die;
      res_nxt.package_index = map_pkg;
      res_nxt.mv            = mv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, res_r.mv.move_to, res_r.mv.move_from, res_r.package_index,
                       res_r.die_index, res_r.plane_index, res_r.block_index,
                       res_r.page_in_block, res_r.physical_page};
  assign out_tuser  = {res_r.range_error, res_r.mv.move_request};

endmodule

@@ rtl/sgwl_map.sv @@
module sgwl_map (
  input  logic [sgwl_pkg::PAGE_W-1:0] logical_page,
  input  sgwl_pkg::map_state_t        st,
  output logic                        range_error,
  output logic [sgwl_pkg::PAGE_W-1:0] physical_page,
  output logic [5:0]                  page_in_block,
  output logic [7:0]                  block_index,
  output logic                        plane_index,
  output logic                        die_index,
  output logic                        package_index
);

  logic [sgwl_pkg::PAGE_W:0]   sum;
  logic [sgwl_pkg::PAGE_W-1:0] wrapped;
  logic [sgwl_pkg::PAGE_W-1:0] pa;

  always_comb begin
    range_error = (logical_page >= sgwl_pkg::SPAN);
    // la is at most SPAN and start is below SPAN, so one subtract brings the sum into range
    sum = {1'b0, logical_page} + {1'b0, st.start_offset};
    if (sum >= {1'b0, sgwl_pkg::SPAN}) begin
      sum = sum - {1'b0, sgwl_pkg::SPAN};
    end
    wrapped = sum[sgwl_pkg::PAGE_W-1:0];
    // skip over the gap
    if (wrapped >= st.gap_position) begin
      pa = wrapped + 1'b1;
    end else begin
      pa = wrapped;
    end
    if (range_error) begin
      pa = '0;
    end
    physical_page = pa;
    page_in_block = 6'(pa[sgwl_pkg::PG_BITS-1:0]);
    block_index   = 8'(pa[sgwl_pkg::BLK_LSB +: sgwl_pkg::BLK_BITS]);
    plane_index   = 1'(pa[sgwl_pkg::PLN_LSB +: sgwl_pkg::PLN_BITS]);
    die_index     = 1'(pa[sgwl_pkg::DIE_LSB +: sgwl_pkg::DIE_BITS]);
    package_index = 1'(pa[sgwl_pkg::PKG_LSB +: sgwl_pkg::PKG_BITS]);
  end

endmodule

@@ rtl/sgwl_ctrl.sv @@
module sgwl_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [sgwl_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                       fire,
  input  sgwl_pkg::action_t          action,
  input  logic                       range_error,
  output sgwl_pkg::map_state_t       st,
  output sgwl_pkg::move_t            mv
);

  logic [sgwl_pkg::CNT_W-1:0]  interval_r;
  logic [sgwl_pkg::PAGE_W-1:0] start_r, start_nxt;
  logic [sgwl_pkg::PAGE_W-1:0] gap_r, gap_nxt;
  logic [sgwl_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        pending_r, pending_nxt;
  logic [sgwl_pkg::CNT_W-1:0]  cnt_inc;
  logic [sgwl_pkg::CNT_W-1:0]  limit;
  logic [sgwl_pkg::PAGE_W-1:0] start_inc;

  assign st.start_offset = start_r;
  assign st.gap_position = gap_r;

  always_comb begin
    start_nxt   = start_r;
    gap_nxt     = gap_r;
    cnt_nxt     = cnt_r;
    pending_nxt = pending_r;
    mv          = '0;
    cnt_inc     = (cnt_r < sgwl_pkg::CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
    limit       = (interval_r == '0) ? sgwl_pkg::CNT_W'(1) : interval_r;
    start_inc   = start_r + 1'b1;
    if (fire) begin
      case (action)
        sgwl_pkg::ACT_WRITE: begin
          if (!range_error) begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= limit && !pending_r) begin
              pending_nxt     = 1'b1;
              cnt_nxt         = '0;
              mv.move_request = 1'b1;
              mv.move_from    = (gap_r == '0) ? sgwl_pkg::SPAN : gap_r - 1'b1;
              mv.move_to      = gap_r;
            end
          end
        end
        sgwl_pkg::ACT_MOVE_DONE: begin
          if (pending_r) begin
            pending_nxt = 1'b0;
            if (gap_r == '0) begin
              gap_nxt   = sgwl_pkg::SPAN;
              start_nxt = (start_inc >= sgwl_pkg::SPAN) ? '0 : start_inc;
            end else begin
              gap_nxt = gap_r - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= sgwl_pkg::INTERVAL_RST;
      start_r    <= '0;
      gap_r      <= sgwl_pkg::SPAN;
      cnt_r      <= '0;
      pending_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
      start_r   <= start_nxt;
      gap_r     <= gap_nxt;
      cnt_r     <= cnt_nxt;
      pending_r <= pending_nxt;
    end
  end

  a_gap_range: assert property (@(posedge clk) disable iff (!rst_n)
    gap_r <= sgwl_pkg::SPAN)
    else $error("gap beyond last physical page");

  a_start_range: assert property (@(posedge clk) disable iff (!rst_n)
    start_r < sgwl_pkg::SPAN)
    else $error("start offset out of range");

  a_req_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    mv.move_request |=> pending_r)
    else $error("move request did not mark a move pending");

  a_req_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mv.move_request |-> !pending_r)
    else $error("second move request while one is pending");

  a_done_rotates: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && action == sgwl_pkg::ACT_MOVE_DONE && pending_r)
      |=> (!pending_r && gap_r != $past(gap_r)))
    else $error("move completion did not rotate the gap");

endmodule
